// ===== sv/psue_pkg.sv =====
// ----------------------------------------------------------------------------
// psue_pkg
// Shared types and constants of the particle store update engine.
// ----------------------------------------------------------------------------
package psue_pkg;

   localparam int MAX_PARTICLES = 256;
   localparam int SORT_PASSES   = 5;
   localparam int IDX_W         = $clog2(MAX_PARTICLES);
   localparam int CNT_W         = $clog2(MAX_PARTICLES + 1);
   localparam int PASS_W        = $clog2(SORT_PASSES + 1);
   localparam int CSR_AW        = 5;

   localparam logic [24:0] AGE_MAX = 25'h1FFFFFF;

   // Transaction function codes.
   localparam logic [1:0] FUNC_TICK    = 2'd0;
   localparam logic [1:0] FUNC_SPAWN   = 2'd1;
   localparam logic [1:0] FUNC_READ    = 2'd2;
   localparam logic [1:0] FUNC_RESTART = 2'd3;

   // Result status codes.
   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   // Spawn modes. The reserved mode behaves like no spawning.
   localparam logic [1:0] MODE_CONTINUOUS = 2'd0;
   localparam logic [1:0] MODE_ONCE       = 2'd1;
   localparam logic [1:0] MODE_NONE       = 2'd2;
   localparam logic [1:0] MODE_RESERVED   = 2'd3;

   // Register indexes.
   localparam logic [2:0] REG_MAX_AGE      = 3'd0;
   localparam logic [2:0] REG_SPAWN_PERIOD = 3'd1;
   localparam logic [2:0] REG_PER_SPAWN    = 3'd2;
   localparam logic [2:0] REG_SPAWN_MODE   = 3'd3;
   localparam logic [2:0] REG_SPIN         = 3'd4;

   typedef struct packed {
      logic [23:0]        max_age;
      logic [23:0]        spawn_period;
      logic [7:0]         per_spawn;
      logic [1:0]         spawn_mode;
      logic signed [31:0] spin;
   } psue_cfg_type;

   typedef struct packed {
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
      logic signed [31:0] rotation;
      logic signed [31:0] spin;
      logic [24:0]        age;
   } psue_entry_type;

   typedef struct packed {
      logic             we;
      logic [IDX_W-1:0] waddr;
      psue_entry_type   wdata;
      logic             re;
      logic [IDX_W-1:0] raddr;
   } psue_mem_req_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_AG_RD,
      ST_AG_EVAL,
      ST_AG_WR,
      ST_CP_WR,
      ST_SR_START,
      ST_SR_SQ,
      ST_SR_CMP,
      ST_SR_END,
      ST_TIMER,
      ST_RD_WAIT,
      ST_DONE
   } psue_state_type;

endpackage

// ===== sv/psue_csr.sv =====
// ----------------------------------------------------------------------------
// psue_csr
// Configuration registers behind an APB-style port.
// ----------------------------------------------------------------------------
module psue_csr (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       psel,
   input  logic                       penable,
   input  logic                       pwrite,
   input  logic [psue_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                pwdata,
   output logic [31:0]                prdata,
   output logic                       pready,
   output psue_pkg::psue_cfg_type     cfg
);
   import psue_pkg::*;

   psue_cfg_type cfg_ff, cfg_in;
   logic [2:0]   reg_idx;
   logic         wr_en;

   assign reg_idx = paddr[CSR_AW-1:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   // Register write decode.
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_MAX_AGE:      cfg_in.max_age      = pwdata[23:0];
            REG_SPAWN_PERIOD: cfg_in.spawn_period = pwdata[23:0];
            REG_PER_SPAWN:    cfg_in.per_spawn    = pwdata[7:0];
            REG_SPAWN_MODE:   cfg_in.spawn_mode   = pwdata[1:0];
            REG_SPIN:         cfg_in.spin         = pwdata;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_age      <= 24'd262144;
         cfg_ff.spawn_period <= 24'd65536;
         cfg_ff.per_spawn    <= 8'd1;
         cfg_ff.spawn_mode   <= MODE_CONTINUOUS;
         cfg_ff.spin         <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Read data mux.
   always_comb begin
      case (reg_idx)
         REG_MAX_AGE:      prdata = {8'd0, cfg_ff.max_age};
         REG_SPAWN_PERIOD: prdata = {8'd0, cfg_ff.spawn_period};
         REG_PER_SPAWN:    prdata = {24'd0, cfg_ff.per_spawn};
         REG_SPAWN_MODE:   prdata = {30'd0, cfg_ff.spawn_mode};
         REG_SPIN:         prdata = cfg_ff.spin;
         default:          prdata = '0;
      endcase
   end

endmodule

// ===== sv/psue_store.sv =====
// ----------------------------------------------------------------------------
// psue_store
// Particle memory: one write port and one registered read port.
// ----------------------------------------------------------------------------
module psue_store (
   input  logic                       clock,
   input  psue_pkg::psue_mem_req_type req,
   output psue_pkg::psue_entry_type   rd_data
);
   import psue_pkg::*;

   psue_entry_type mem [MAX_PARTICLES];
   psue_entry_type rd_data_ff;

   assign rd_data = rd_data_ff;

   always_ff @(posedge clock) begin
      if (req.we) begin
         mem[req.waddr] <= req.wdata;
      end
      if (req.re) begin
         rd_data_ff <= mem[req.raddr];
      end
   end

endmodule

// ===== sv/psue_engine.sv =====
// ----------------------------------------------------------------------------
// psue_engine
// Sequencer that spawns, ages, integrates, sorts and reads the particle memory.
// ----------------------------------------------------------------------------
module psue_engine (
   input  logic                   clock,
   input  logic                   reset,
   input  psue_pkg::psue_cfg_type cfg,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [1:0]             req_func,
   input  logic [19:0]            req_dt,
   input  logic signed [31:0]     req_cam_x,
   input  logic signed [31:0]     req_cam_y,
   input  logic signed [31:0]     req_cam_z,
   input  logic signed [31:0]     req_new_pos_x,
   input  logic signed [31:0]     req_new_pos_y,
   input  logic signed [31:0]     req_new_pos_z,
   input  logic signed [31:0]     req_new_vel_x,
   input  logic signed [31:0]     req_new_vel_y,
   input  logic signed [31:0]     req_new_vel_z,
   input  logic [7:0]             req_read_index,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [8:0]             rsp_live_count,
   output logic [7:0]             rsp_spawns_due,
   output logic signed [31:0]     rsp_out_pos_x,
   output logic signed [31:0]     rsp_out_pos_y,
   output logic signed [31:0]     rsp_out_pos_z,
   output logic signed [31:0]     rsp_out_rotation,
   output logic [24:0]            rsp_out_age
);
   import psue_pkg::*;

   // Saturating position update with a floored Q16.16 step.
   function automatic logic signed [31:0] sat_add(input logic signed [31:0] p,
                                                  input logic signed [52:0] prod);
      logic signed [52:0] step;
      logic signed [37:0] sum;
      begin
         step = prod >>> 16;
         sum  = 38'(p) + 38'(step);
         if (sum > 38'sd2147483647) begin
            sat_add = 32'sh7FFFFFFF;
         end else if (sum < -38'sd2147483648) begin
            sat_add = 32'sh80000000;
         end else begin
            sat_add = sum[31:0];
         end
      end
   endfunction

   psue_state_type   state_ff, state_in;
   psue_mem_req_type mem_req;
   psue_entry_type   rd_data;

   logic [CNT_W-1:0]   idx_ff, count_ff, idx_next;
   logic [PASS_W-1:0]  pass_ff;
   logic [24:0]        timer_ff;
   logic               aged_ff;
   logic [19:0]        dt_ff;
   logic signed [31:0] cam_x_ff, cam_y_ff, cam_z_ff;
   psue_entry_type     carried_ff;
   logic [67:0]        carried_dist_ff;
   logic [65:0]        sq_x_ff, sq_y_ff, sq_z_ff;
   logic signed [52:0] prod_x_ff, prod_y_ff, prod_z_ff, prod_r_ff;
   logic [24:0]        age_new_ff;

   logic [1:0]         res_status_ff;
   logic [7:0]         res_due_ff;
   logic signed [31:0] res_x_ff, res_y_ff, res_z_ff, res_rot_ff;
   logic [24:0]        res_age_ff;

   logic               rsp_valid_ff;
   logic [1:0]         rsp_status_ff;
   logic [8:0]         rsp_count_ff;
   logic [7:0]         rsp_due_ff;
   logic signed [31:0] rsp_x_ff, rsp_y_ff, rsp_z_ff, rsp_rot_ff;
   logic [24:0]        rsp_age_ff;

   logic               accept, rsp_load, kill, swap, more, in_range;
   logic [25:0]        age_sum;
   logic [24:0]        age_sat;
   logic signed [20:0] dt_s;
   logic signed [32:0] dx, dy, dz;
   logic [67:0]        cur_dist;
   logic signed [31:0] rot_sum;
   logic signed [52:0] rot_step;

   psue_store u_store (
      .clock   (clock),
      .req     (mem_req),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);
   assign in_range  = {1'b0, req_read_index} < count_ff;

   // Aging, integration and sort datapath terms.
   assign age_sum  = {1'b0, rd_data.age} + {6'd0, dt_ff};
   assign age_sat  = (age_sum > {1'b0, AGE_MAX}) ? AGE_MAX : age_sum[24:0];
   assign kill     = age_sat > {1'b0, cfg.max_age};
   assign dt_s     = {1'b0, dt_ff};
   assign dx       = 33'(rd_data.pos_x) - 33'(cam_x_ff);
   assign dy       = 33'(rd_data.pos_y) - 33'(cam_y_ff);
   assign dz       = 33'(rd_data.pos_z) - 33'(cam_z_ff);
   assign cur_dist = 68'(sq_x_ff) + 68'(sq_y_ff) + 68'(sq_z_ff);
   assign swap     = cur_dist > carried_dist_ff;
   assign idx_next = idx_ff + 1'b1;
   assign more     = idx_next < count_ff;
   assign rot_step = prod_r_ff >>> 16;
   assign rot_sum  = rd_data.rotation + rot_step[31:0];

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_func)
                  FUNC_TICK: state_in = ST_AG_RD;
                  FUNC_READ: state_in = in_range ? ST_RD_WAIT : ST_DONE;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_AG_RD:    state_in = (idx_ff < count_ff) ? ST_AG_EVAL : ST_SR_START;
         ST_AG_EVAL:  state_in = kill ? ST_CP_WR : ST_AG_WR;
         ST_AG_WR:    state_in = ST_AG_RD;
         ST_CP_WR:    state_in = ST_AG_RD;
         ST_SR_START: state_in = (count_ff < CNT_W'(2)) ? ST_TIMER : ST_SR_SQ;
         ST_SR_SQ:    state_in = ST_SR_CMP;
         ST_SR_CMP:   state_in = more ? ST_SR_SQ : ST_SR_END;
         ST_SR_END: begin
            state_in = (pass_ff == PASS_W'(SORT_PASSES - 1)) ? ST_TIMER : ST_SR_START;
         end
         ST_TIMER:    state_in = ST_DONE;
         ST_RD_WAIT:  state_in = ST_DONE;
         ST_DONE:     state_in = rsp_load ? ST_IDLE : ST_DONE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Memory requests for each state.
   always_comb begin
      mem_req       = '0;
      mem_req.wdata = rd_data;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_func == FUNC_SPAWN && count_ff < CNT_W'(MAX_PARTICLES)) begin
               mem_req.we             = 1'b1;
               mem_req.waddr          = count_ff[IDX_W-1:0];
               mem_req.wdata.pos_x    = req_new_pos_x;
               mem_req.wdata.pos_y    = req_new_pos_y;
               mem_req.wdata.pos_z    = req_new_pos_z;
               mem_req.wdata.vel_x    = req_new_vel_x;
               mem_req.wdata.vel_y    = req_new_vel_y;
               mem_req.wdata.vel_z    = req_new_vel_z;
               mem_req.wdata.rotation = '0;
               mem_req.wdata.spin     = cfg.spin;
               mem_req.wdata.age      = '0;
            end
            if (accept && req_func == FUNC_READ && in_range) begin
               mem_req.re    = 1'b1;
               mem_req.raddr = req_read_index;
            end
         end
         ST_AG_RD: begin
            mem_req.re    = idx_ff < count_ff;
            mem_req.raddr = idx_ff[IDX_W-1:0];
         end
         ST_AG_EVAL: begin
            // A dying particle is replaced by the last live entry.
            mem_req.re    = kill;
            mem_req.raddr = 8'(count_ff - 1'b1);
         end
         ST_CP_WR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = idx_ff[IDX_W-1:0];
         end
         ST_AG_WR: begin
            mem_req.we             = 1'b1;
            mem_req.waddr          = idx_ff[IDX_W-1:0];
            mem_req.wdata.pos_x    = sat_add(rd_data.pos_x, prod_x_ff);
            mem_req.wdata.pos_y    = sat_add(rd_data.pos_y, prod_y_ff);
            mem_req.wdata.pos_z    = sat_add(rd_data.pos_z, prod_z_ff);
            mem_req.wdata.rotation = rot_sum;
            mem_req.wdata.age      = age_new_ff;
         end
         ST_SR_START: begin
            mem_req.re    = !(count_ff < CNT_W'(2));
            mem_req.raddr = '0;
         end
         ST_SR_CMP: begin
            // The farther of the pair settles at the lower slot.
            mem_req.we    = (idx_ff != '0);
            mem_req.waddr = 8'(idx_ff - 1'b1);
            mem_req.wdata = swap ? rd_data : carried_ff;
            mem_req.re    = more;
            mem_req.raddr = idx_next[IDX_W-1:0];
         end
         ST_SR_END: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = 8'(count_ff - 1'b1);
            mem_req.wdata = carried_ff;
         end
         default: mem_req.re = 1'b0;
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         timer_ff     <= '0;
         aged_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
         pass_ff      <= '0;
      end else begin
         state_ff <= state_in;
         case (state_ff)
            ST_IDLE: begin
               idx_ff  <= '0;
               pass_ff <= '0;
               if (accept && req_func == FUNC_SPAWN && count_ff < CNT_W'(MAX_PARTICLES)) begin
                  count_ff <= count_ff + 1'b1;
               end
               if (accept && req_func == FUNC_RESTART) begin
                  count_ff <= '0;
                  timer_ff <= '0;
                  aged_ff  <= 1'b0;
               end
            end
            ST_AG_EVAL: begin
               if (kill) begin
                  count_ff <= count_ff - 1'b1;
               end
            end
            ST_AG_WR:    idx_ff <= idx_next;
            ST_SR_START: idx_ff <= '0;
            ST_SR_CMP:   idx_ff <= idx_next;
            ST_SR_END:   pass_ff <= pass_ff + 1'b1;
            ST_TIMER: begin
               if (cfg.spawn_mode == MODE_CONTINUOUS && cfg.spawn_period != '0) begin
                  if (timer_ff > {1'b0, cfg.spawn_period}) begin
                     timer_ff <= timer_ff - {1'b0, cfg.spawn_period};
                  end else if ({1'b0, timer_ff} + {6'd0, dt_ff} > {1'b0, AGE_MAX}) begin
                     timer_ff <= AGE_MAX;
                  end else begin
                     timer_ff <= timer_ff + {5'd0, dt_ff};
                  end
               end else if (cfg.spawn_mode == MODE_ONCE && !aged_ff) begin
                  timer_ff <= (timer_ff > {1'b0, cfg.spawn_period}) ?
                              timer_ff - {1'b0, cfg.spawn_period} : '0;
               end
               if (dt_ff != '0) begin
                  aged_ff <= 1'b1;
               end
            end
            default: idx_ff <= idx_ff;
         endcase
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath and result registers.
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               dt_ff         <= req_dt;
               cam_x_ff      <= req_cam_x;
               cam_y_ff      <= req_cam_y;
               cam_z_ff      <= req_cam_z;
               res_due_ff    <= '0;
               res_x_ff      <= '0;
               res_y_ff      <= '0;
               res_z_ff      <= '0;
               res_rot_ff    <= '0;
               res_age_ff    <= '0;
               res_status_ff <= STATUS_OK;
               if (req_func == FUNC_SPAWN && !(count_ff < CNT_W'(MAX_PARTICLES))) begin
                  res_status_ff <= STATUS_FULL;
               end
               if (req_func == FUNC_READ && !in_range) begin
                  res_status_ff <= STATUS_RANGE;
               end
            end
         end
         ST_AG_EVAL: begin
            age_new_ff <= age_sat;
            prod_x_ff  <= rd_data.vel_x * dt_s;
            prod_y_ff  <= rd_data.vel_y * dt_s;
            prod_z_ff  <= rd_data.vel_z * dt_s;
            prod_r_ff  <= rd_data.spin * dt_s;
         end
         ST_SR_SQ: begin
            sq_x_ff <= 66'(dx * dx);
            sq_y_ff <= 66'(dy * dy);
            sq_z_ff <= 66'(dz * dz);
         end
         ST_SR_CMP: begin
            if (idx_ff == '0 || !swap) begin
               carried_ff      <= rd_data;
               carried_dist_ff <= cur_dist;
            end
         end
         ST_TIMER: begin
            if (cfg.spawn_mode == MODE_CONTINUOUS && cfg.spawn_period != '0 &&
                timer_ff > {1'b0, cfg.spawn_period}) begin
               res_due_ff <= cfg.per_spawn;
            end else if (cfg.spawn_mode == MODE_ONCE && !aged_ff) begin
               res_due_ff <= cfg.per_spawn;
            end
         end
         ST_RD_WAIT: begin
            res_x_ff   <= rd_data.pos_x;
            res_y_ff   <= rd_data.pos_y;
            res_z_ff   <= rd_data.pos_z;
            res_rot_ff <= rd_data.rotation;
            res_age_ff <= rd_data.age;
         end
         default: res_due_ff <= res_due_ff;
      endcase
      if (rsp_load) begin
         rsp_status_ff <= res_status_ff;
         rsp_count_ff  <= count_ff;
         rsp_due_ff    <= res_due_ff;
         rsp_x_ff      <= res_x_ff;
         rsp_y_ff      <= res_y_ff;
         rsp_z_ff      <= res_z_ff;
         rsp_rot_ff    <= res_rot_ff;
         rsp_age_ff    <= res_age_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_live_count   = rsp_count_ff;
   assign rsp_spawns_due   = rsp_due_ff;
   assign rsp_out_pos_x    = rsp_x_ff;
   assign rsp_out_pos_y    = rsp_y_ff;
   assign rsp_out_pos_z    = rsp_z_ff;
   assign rsp_out_rotation = rsp_rot_ff;
   assign rsp_out_age      = rsp_age_ff;

   // The live count never passes the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PARTICLES))
      else $error("live count above store depth");

   // An idle write comes only from an accepted spawn.
   a_idle_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && mem_req.we) |-> (accept && req_func == FUNC_SPAWN))
      else $error("memory write while idle without spawn");

   // Integration writes back only live slots.
   a_wb_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_AG_WR) |-> (idx_ff < count_ff))
      else $error("write-back beyond live count");

   // A restart empties the store.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      (accept && req_func == FUNC_RESTART) |=> (count_ff == '0))
      else $error("restart left particles");

endmodule

// ===== sv/particle_store_update_engine_core.sv =====
// ----------------------------------------------------------------------------
// particle_store_update_engine_core
// Particle store with aging, integration, depth sort and spawn timing.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake            Contents
//  req_     in         req_valid/req_ready  function, tick step, camera, spawn data
//  rsp_     out        rsp_valid/rsp_ready  status, live count, spawns due, particle
//  csr      in/out     psel/penable/pready  five configuration registers
//
// One transaction is worked on at a time over the particle memory, which has one
// write port and one registered read port. A tick ages and integrates each live
// particle (a removed particle's replacement is visited again), then runs five sort
// passes (none when fewer than two are live) and then updates the spawn timer.
// Reset is synchronous and empties the store; a finished result waits in the output
// register while rsp_ready is low.
module particle_store_update_engine_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [1:0]                  req_func,
   input  logic [19:0]                 req_dt,
   input  logic signed [31:0]          req_cam_x,
   input  logic signed [31:0]          req_cam_y,
   input  logic signed [31:0]          req_cam_z,
   input  logic signed [31:0]          req_new_pos_x,
   input  logic signed [31:0]          req_new_pos_y,
   input  logic signed [31:0]          req_new_pos_z,
   input  logic signed [31:0]          req_new_vel_x,
   input  logic signed [31:0]          req_new_vel_y,
   input  logic signed [31:0]          req_new_vel_z,
   input  logic [7:0]                  req_read_index,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [1:0]                  rsp_status,
   output logic [8:0]                  rsp_live_count,
   output logic [7:0]                  rsp_spawns_due,
   output logic signed [31:0]          rsp_out_pos_x,
   output logic signed [31:0]          rsp_out_pos_y,
   output logic signed [31:0]          rsp_out_pos_z,
   output logic signed [31:0]          rsp_out_rotation,
   output logic [24:0]                 rsp_out_age,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [psue_pkg::CSR_AW-1:0] paddr,
   input  logic [31:0]                 pwdata,
   output logic [31:0]                 prdata,
   output logic                        pready
);
   import psue_pkg::*;

   psue_cfg_type cfg;

   // Configuration registers.
   psue_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Sequencer and particle memory.
   psue_engine u_engine (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_func         (req_func),
      .req_dt           (req_dt),
      .req_cam_x        (req_cam_x),
      .req_cam_y        (req_cam_y),
      .req_cam_z        (req_cam_z),
      .req_new_pos_x    (req_new_pos_x),
      .req_new_pos_y    (req_new_pos_y),
      .req_new_pos_z    (req_new_pos_z),
      .req_new_vel_x    (req_new_vel_x),
      .req_new_vel_y    (req_new_vel_y),
      .req_new_vel_z    (req_new_vel_z),
      .req_read_index   (req_read_index),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_live_count   (rsp_live_count),
      .rsp_spawns_due   (rsp_spawns_due),
      .rsp_out_pos_x    (rsp_out_pos_x),
      .rsp_out_pos_y    (rsp_out_pos_y),
      .rsp_out_pos_z    (rsp_out_pos_z),
      .rsp_out_rotation (rsp_out_rotation),
      .rsp_out_age      (rsp_out_age)
   );

endmodule
